// File: sv/fbra_pkg.sv
// ----------------------------------------------------------------------------
// fbra_pkg
// Shared widths, register indexes and request codes of the frame bitmap run
// allocator.
// ----------------------------------------------------------------------------
package fbra_pkg;

   // Payload and register widths
   localparam int START_W = 16;   // frame number on the request side
   localparam int LEN_W   = 9;    // run length
   localparam int IDX_W   = 16;   // frame number on the response side
   localparam int NF_W    = 17;   // num_frames register, widest register
   localparam int CSR_W   = 1;    // register index

   // Parameter defaults
   localparam int DEF_MAX_FRAMES = 65536;
   localparam int DEF_MAX_RUN    = 256;
   localparam int DEF_WORD_BITS  = 64;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_NUM_FRAMES   = 1'b0;
   localparam logic [CSR_W-1:0] CSR_SEARCH_START = 1'b1;

   // Register reset values
   localparam logic [NF_W-1:0]    NUM_FRAMES_RST   = 17'd65536;
   localparam logic [START_W-1:0] SEARCH_START_RST = 16'd0;

   // Request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

endpackage

// File: sv/frame_bitmap_run_allocator_core.sv
// ----------------------------------------------------------------------------
// frame_bitmap_run_allocator_core
// First-fit run allocator over a used/free bitmap of physical frames.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): req_type 0 allocates a run of
//   req_run_length frames, req_type 1 frees the run starting at
//   req_start_frame. One request is in work at a time; req_stall is high
//   while the block is busy. Every request gives exactly one response
//   (rsp_valid / rsp_stall): rsp_frame_index is the start of the allocated
//   run, rsp_ok is 0 when an allocation fails.
//   An allocate passes through setup (accept, divider load, divider result),
//   a word scan that reads and skips full bitmap words, a run search over
//   one frame at a time that reads each new word, a read and a write per
//   word marked, and the output register. A free has the same setup, a read
//   and a write per word touched and the response. A rejected allocate or a
//   zero-length free goes from the accept straight to the response. The
//   read-modify-write over the bitmap memory sets the pace.
//   Reset: the bitmap is swept to all used, one word per cycle, NUM_WORDS
//   words (1024 at defaults); requests stall during the sweep, register
//   writes are taken at any time.
//   A stalled response holds in the output register; the next request is
//   still accepted and worked on, and waits to deliver until it drains.
// ----------------------------------------------------------------------------
module frame_bitmap_run_allocator_core #(
   parameter int MAX_FRAMES = fbra_pkg::DEF_MAX_FRAMES,
   parameter int MAX_RUN    = fbra_pkg::DEF_MAX_RUN,
   parameter int WORD_BITS  = fbra_pkg::DEF_WORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [fbra_pkg::START_W-1:0] req_start_frame,
   input  logic [fbra_pkg::LEN_W-1:0]   req_run_length,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fbra_pkg::IDX_W-1:0]   rsp_frame_index,
   output logic                         rsp_ok,
   // register write port
   input  logic                         csr_wr_en,
   input  logic [fbra_pkg::CSR_W-1:0]   csr_index,
   input  logic [fbra_pkg::NF_W-1:0]    csr_wdata
);

   localparam int START_W   = fbra_pkg::START_W;
   localparam int LEN_W     = fbra_pkg::LEN_W;
   localparam int IDX_W     = fbra_pkg::IDX_W;
   localparam int NF_W      = fbra_pkg::NF_W;
   localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int FCW       = $clog2(MAX_FRAMES + 2 ** START_W + MAX_RUN + 2 * WORD_BITS + 1);
   localparam int WIW       = $clog2(NUM_WORDS + (2 ** START_W) / WORD_BITS + 2);
   localparam int BIT_W     = $clog2(WORD_BITS);

   localparam logic [3:0] ST_CLR    = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DIV1   = 4'd2;
   localparam logic [3:0] ST_DIV2   = 4'd3;
   localparam logic [3:0] ST_WS_RD  = 4'd4;
   localparam logic [3:0] ST_WS_CHK = 4'd5;
   localparam logic [3:0] ST_SC_RD  = 4'd6;
   localparam logic [3:0] ST_SC_BIT = 4'd7;
   localparam logic [3:0] ST_MK_RD  = 4'd8;
   localparam logic [3:0] ST_MK_WR  = 4'd9;
   localparam logic [3:0] ST_RESP   = 4'd10;

   localparam logic [WORD_BITS-1:0] WORD_FULL = '1;

   // control state
   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [NF_W-1:0]    num_frames_ff;
   logic [START_W-1:0] search_start_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // working registers
   logic               type_ff, type_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [FCW-1:0]     len_ff, len_in;
   logic [FCW-1:0]     nf_ff, nf_in;
   logic [FCW-1:0]     limit_ff, limit_in;
   logic [WIW-1:0]     w_ff, w_in;
   logic [FCW-1:0]     wbase_ff, wbase_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [FCW-1:0]     f_ff, f_in;
   logic [FCW-1:0]     run_start_ff, run_start_in;
   logic [LEN_W-1:0]   run_ff, run_in;
   logic [WIW-1:0]     rs_w_ff, rs_w_in;
   logic [FCW-1:0]     rs_wbase_ff, rs_wbase_in;
   logic [FCW-1:0]     lo_ff, lo_in;
   logic [FCW-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic               res_ok_ff, res_ok_in;
   logic [IDX_W-1:0]   rsp_frame_index_ff, rsp_frame_index_in;
   logic               rsp_ok_ff, rsp_ok_in;

   // request decode
   logic [FCW-1:0]     req_len_x;
   logic [FCW-1:0]     max_run_x;
   logic [FCW-1:0]     max_frames_x;
   logic [FCW-1:0]     word_bits_x;
   logic [FCW-1:0]     nf_now;
   logic [FCW-1:0]     len_clip;
   logic [FCW-1:0]     free_start_x;
   logic [FCW-1:0]     free_end;
   logic [FCW-1:0]     free_hi;
   logic               alloc_bad;
   logic               free_none;

   // scan and mark helpers
   logic               scan_live;
   logic               bit_used;
   logic               at_word_end;
   logic [FCW-1:0]     lo_off;
   logic [FCW-1:0]     hi_off;
   logic [BIT_W-1:0]   s_amt;
   logic [BIT_W:0]     e_amt;
   logic [WORD_BITS-1:0] mark_mask;

   // memory and divider ports
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [WORD_BITS-1:0] mem_rd_data;
   logic                 div_load;
   logic [START_W-1:0]   div_x;
   logic [WIW-1:0]       div_q;
   logic [BIT_W-1:0]     div_r;

   fbra_bitmap_mem #(
      .WORD_BITS (WORD_BITS),
      .NUM_WORDS (NUM_WORDS),
      .ADDR_W    (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (w_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   // frame number to word index and bit offset
   fbra_word_div #(
      .WORD_BITS (WORD_BITS),
      .QW        (WIW),
      .BIT_W     (BIT_W)
   ) u_div (
      .clock (clock),
      .load  (div_load),
      .x     (div_x),
      .q     (div_q),
      .r     (div_r)
   );

   assign div_x = (type_ff == fbra_pkg::REQ_FREE) ? start_ff : search_start_ff;

   // request decode, used in the accept cycle
   assign req_len_x    = FCW'(req_run_length);
   assign max_run_x    = FCW'(MAX_RUN);
   assign max_frames_x = FCW'(MAX_FRAMES);
   assign word_bits_x  = FCW'(WORD_BITS);
   assign nf_now       = (FCW'(num_frames_ff) > max_frames_x) ? max_frames_x
                                                              : FCW'(num_frames_ff);
   assign len_clip     = (req_len_x > max_run_x) ? max_run_x : req_len_x;
   assign alloc_bad    = (req_len_x == '0) || (req_len_x > max_run_x) || (req_len_x > nf_now);
   assign free_start_x = FCW'(req_start_frame);
   assign free_end     = free_start_x + len_clip;
   assign free_hi      = (free_end > max_frames_x) ? max_frames_x : free_end;
   assign free_none    = (len_clip == '0) || (free_start_x >= max_frames_x);

   // run search step
   assign scan_live   = (run_start_ff <= limit_ff) && (f_ff < nf_ff);
   assign bit_used    = mem_rd_data[bit_ff];
   assign at_word_end = (bit_ff == BIT_W'(WORD_BITS - 1));

   // bits of the current word that fall inside [lo, hi)
   assign lo_off    = lo_ff - wbase_ff;
   assign hi_off    = hi_ff - wbase_ff;
   assign s_amt     = (lo_ff > wbase_ff) ? lo_off[BIT_W-1:0] : '0;
   assign e_amt     = (hi_off >= word_bits_x) ? (BIT_W + 1)'(WORD_BITS) : hi_off[BIT_W:0];
   assign mark_mask = ~(WORD_FULL << e_amt) & (WORD_FULL << s_amt);

   always_comb begin
      state_in           = state_ff;
      clr_in             = clr_ff;
      type_in            = type_ff;
      start_in           = start_ff;
      len_in             = len_ff;
      nf_in              = nf_ff;
      limit_in           = limit_ff;
      w_in               = w_ff;
      wbase_in           = wbase_ff;
      bit_in             = bit_ff;
      f_in               = f_ff;
      run_start_in       = run_start_ff;
      run_in             = run_ff;
      rs_w_in            = rs_w_ff;
      rs_wbase_in        = rs_wbase_ff;
      lo_in              = lo_ff;
      hi_in              = hi_ff;
      res_idx_in         = res_idx_ff;
      res_ok_in          = res_ok_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_frame_index_in = rsp_frame_index_ff;
      rsp_ok_in          = rsp_ok_ff;
      mem_wr_en          = 1'b0;
      mem_wr_addr        = w_ff[ADDR_W-1:0];
      mem_wr_data        = WORD_FULL;
      mem_rd_en          = 1'b0;
      div_load           = 1'b0;

      unique case (state_ff)
         ST_CLR: begin
            // sweep every word to all used
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(NUM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               type_in  = req_type;
               start_in = req_start_frame;
               nf_in    = nf_now;
               limit_in = nf_now - req_len_x;
               lo_in    = free_start_x;
               hi_in    = free_hi;
               if (req_type == fbra_pkg::REQ_FREE) begin
                  len_in     = len_clip;
                  res_idx_in = '0;
                  res_ok_in  = 1'b1;
                  state_in   = free_none ? ST_RESP : ST_DIV1;
               end else begin
                  len_in = req_len_x;
                  if (alloc_bad) begin
                     res_idx_in = '0;
                     res_ok_in  = 1'b0;
                     state_in   = ST_RESP;
                  end else begin
                     state_in = ST_DIV1;
                  end
               end
            end
         end

         ST_DIV1: begin
            div_load = 1'b1;
            state_in = ST_DIV2;
         end

         ST_DIV2: begin
            w_in     = div_q;
            wbase_in = FCW'(div_x) - FCW'(div_r);
            state_in = (type_ff == fbra_pkg::REQ_FREE) ? ST_MK_RD : ST_WS_RD;
         end

         ST_WS_RD: begin
            if ((w_ff < WIW'(NUM_WORDS)) && (wbase_ff <= limit_ff)) begin
               mem_rd_en = 1'b1;
               state_in  = ST_WS_CHK;
            end else begin
               res_idx_in = '0;
               res_ok_in  = 1'b0;
               state_in   = ST_RESP;
            end
         end

         ST_WS_CHK: begin
            if (mem_rd_data != WORD_FULL) begin
               // word already in the read register: start the run search here
               run_start_in = wbase_ff;
               f_in         = wbase_ff;
               bit_in       = '0;
               run_in       = '0;
               rs_w_in      = w_ff;
               rs_wbase_in  = wbase_ff;
               state_in     = ST_SC_BIT;
            end else begin
               w_in     = w_ff + WIW'(1);
               wbase_in = wbase_ff + word_bits_x;
               state_in = ST_WS_RD;
            end
         end

         ST_SC_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_SC_BIT;
         end

         ST_SC_BIT: begin
            if (!scan_live) begin
               res_idx_in = '0;
               res_ok_in  = 1'b0;
               state_in   = ST_RESP;
            end else if (!bit_used && ((FCW'(run_ff) + FCW'(1)) == len_ff)) begin
               // run complete: go mark it, starting at the word of its start
               lo_in      = run_start_ff;
               hi_in      = run_start_ff + len_ff;
               w_in       = rs_w_ff;
               wbase_in   = rs_wbase_ff;
               res_idx_in = run_start_ff[IDX_W-1:0];
               res_ok_in  = 1'b1;
               state_in   = ST_MK_RD;
            end else begin
               if (bit_used) begin
                  run_start_in = f_ff + FCW'(1);
                  run_in       = '0;
                  rs_w_in      = at_word_end ? (w_ff + WIW'(1)) : w_ff;
                  rs_wbase_in  = at_word_end ? (wbase_ff + word_bits_x) : wbase_ff;
               end else begin
                  run_in = run_ff + LEN_W'(1);
               end
               f_in = f_ff + FCW'(1);
               if (at_word_end) begin
                  bit_in   = '0;
                  w_in     = w_ff + WIW'(1);
                  wbase_in = wbase_ff + word_bits_x;
                  state_in = ST_SC_RD;
               end else begin
                  bit_in = bit_ff + BIT_W'(1);
               end
            end
         end

         ST_MK_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_MK_WR;
         end

         ST_MK_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (type_ff == fbra_pkg::REQ_FREE) ? (mem_rd_data & ~mark_mask)
                                                          : (mem_rd_data | mark_mask);
            if (hi_ff > (wbase_ff + word_bits_x)) begin
               w_in     = w_ff + WIW'(1);
               wbase_in = wbase_ff + word_bits_x;
               state_in = ST_MK_RD;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // load the output register once it is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_frame_index_in = res_idx_ff;
               rsp_ok_in          = res_ok_ff;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         num_frames_ff   <= fbra_pkg::NUM_FRAMES_RST;
         search_start_ff <= fbra_pkg::SEARCH_START_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               fbra_pkg::CSR_NUM_FRAMES:   num_frames_ff   <= csr_wdata;
               fbra_pkg::CSR_SEARCH_START: search_start_ff <= csr_wdata[START_W-1:0];
               default:                    num_frames_ff   <= num_frames_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      type_ff            <= type_in;
      start_ff           <= start_in;
      len_ff             <= len_in;
      nf_ff              <= nf_in;
      limit_ff           <= limit_in;
      w_ff               <= w_in;
      wbase_ff           <= wbase_in;
      bit_ff             <= bit_in;
      f_ff               <= f_in;
      run_start_ff       <= run_start_in;
      run_ff             <= run_in;
      rs_w_ff            <= rs_w_in;
      rs_wbase_ff        <= rs_wbase_in;
      lo_ff              <= lo_in;
      hi_ff              <= hi_in;
      res_idx_ff         <= res_idx_in;
      res_ok_ff          <= res_ok_in;
      rsp_frame_index_ff <= rsp_frame_index_in;
      rsp_ok_ff          <= rsp_ok_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = rsp_frame_index_ff;
   assign rsp_ok          = rsp_ok_ff;

   // the bitmap is never written while the search is reading it
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WS_CHK) || (state_ff == ST_SC_BIT)) |-> !mem_wr_en)
      else $error("bitmap written during search");

   // an allocated run never reaches past the frames present
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MK_WR) && (type_ff == fbra_pkg::REQ_ALLOC)) |-> (hi_ff <= nf_ff))
      else $error("allocated run beyond num_frames");

   // the free count stays below the requested length while scanning
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SC_BIT) |-> (FCW'(run_ff) < len_ff))
      else $error("run count reached length without completing");

   // every word visited by a mark pass holds part of the run
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MK_WR) |-> (mark_mask != '0))
      else $error("empty mark mask");

endmodule

// File: sv/fbra_bitmap_mem.sv
// ----------------------------------------------------------------------------
// fbra_bitmap_mem
// Used/free bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbra_bitmap_mem #(
   parameter int WORD_BITS = fbra_pkg::DEF_WORD_BITS,
   parameter int NUM_WORDS = fbra_pkg::DEF_MAX_FRAMES / fbra_pkg::DEF_WORD_BITS,
   parameter int ADDR_W    = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fbra_word_div.sv
// ----------------------------------------------------------------------------
// fbra_word_div
// Splits a frame number into word index and bit offset: reciprocal multiply
// in the load cycle, back-multiply and one correction step in the next.
// ----------------------------------------------------------------------------
module fbra_word_div #(
   parameter int WORD_BITS = fbra_pkg::DEF_WORD_BITS,
   parameter int QW        = 14,
   parameter int BIT_W     = 6
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [fbra_pkg::START_W-1:0] x,
   output logic [QW-1:0]                q,
   output logic [BIT_W-1:0]             r
);

   localparam int XW    = fbra_pkg::START_W;
   localparam int SH    = XW + 1;
   localparam int RECIP = (2 ** SH) / WORD_BITS;
   localparam int RCW   = $clog2(RECIP + 1);
   localparam int PW    = XW + RCW;

   logic [PW-1:0]    prod_ff;
   logic [PW-1:0]    prod_in;
   logic [PW-SH-1:0] q_est;
   logic [XW:0]      back;
   logic [XW:0]      rem;

   assign prod_in = PW'(x) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // estimate is exact or one low
   assign q_est = prod_ff[PW-1:SH];
   assign back  = (XW + 1)'(q_est) * (XW + 1)'(WORD_BITS);
   assign rem   = {1'b0, x} - back;

   always_comb begin
      if (rem >= (XW + 1)'(WORD_BITS)) begin
         q = QW'(q_est) + QW'(1);
         r = BIT_W'(rem - (XW + 1)'(WORD_BITS));
      end else begin
         q = QW'(q_est);
         r = BIT_W'(rem);
      end
   end

endmodule

// File: sim/fbra_grant_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbra_grant_checker
// Watches the request, response and register ports of the frame bitmap run
// allocator. Keeps a shadow bitmap and register copy, works out the expected
// response of every accepted request and compares each delivered response.
// ----------------------------------------------------------------------------
module fbra_grant_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_type,
   input  logic [fbra_pkg::START_W-1:0] req_start_frame,
   input  logic [fbra_pkg::LEN_W-1:0]   req_run_length,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [fbra_pkg::IDX_W-1:0]   rsp_frame_index,
   input  logic                         rsp_ok,
   input  logic                         csr_wr_en,
   input  logic [fbra_pkg::CSR_W-1:0]   csr_index,
   input  logic [fbra_pkg::NF_W-1:0]    csr_wdata,
   output int                           outstanding,
   output int                           fail_count
);

   localparam int START_W     = fbra_pkg::START_W;
   localparam int LEN_W       = fbra_pkg::LEN_W;
   localparam int IDX_W       = fbra_pkg::IDX_W;
   localparam int NF_W        = fbra_pkg::NF_W;
   localparam int MAX_FRAMES  = fbra_pkg::DEF_MAX_FRAMES;
   localparam int MAX_RUN     = fbra_pkg::DEF_MAX_RUN;
   localparam int WORD_BITS   = fbra_pkg::DEF_WORD_BITS;
   localparam int NUM_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int PRINT_LIMIT = 50;
   localparam logic [WORD_BITS-1:0] WORD_FULL = {WORD_BITS{1'b1}};

   typedef struct packed {
      logic [IDX_W-1:0] frame_index;
      logic             ok;
   } grant_type;

   logic [WORD_BITS-1:0] shadow_used [NUM_WORDS];
   logic [NF_W-1:0]      frames_present;
   logic [START_W-1:0]   hint_frame;
   grant_type            pending_grants [$];

   task automatic report_failure(input string msg);
      if (fail_count < PRINT_LIMIT) $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic bit frame_is_used(input int unsigned f);
      if (f >= MAX_FRAMES) return 1'b1;
      return shadow_used[f / WORD_BITS][f % WORD_BITS];
   endfunction

   function automatic void mark_frame(input int unsigned f, input bit used);
      if (f < MAX_FRAMES) shadow_used[f / WORD_BITS][f % WORD_BITS] = used;
   endfunction

   // First-fit search from the word holding the hint; a free clears at most
   // MAX_RUN frames and always succeeds.
   function automatic grant_type predict_grant(input logic kind,
                                               input logic [START_W-1:0] start,
                                               input logic [LEN_W-1:0] len);
      grant_type   grant;
      int unsigned count, nf, limit, w, run_start, run, f, k;
      bit          found;
      grant = '0;
      count = 32'(len);
      found = 1'b0;
      if (kind == fbra_pkg::REQ_FREE) begin
         if (count > MAX_RUN) count = MAX_RUN;
         for (k = 0; k < count; k++) mark_frame(32'(start) + k, 1'b0);
         grant.ok = 1'b1;
         return grant;
      end
      nf = 32'(frames_present);
      if (nf > MAX_FRAMES) nf = MAX_FRAMES;
      if (count == 0 || count > MAX_RUN || count > nf) return grant;
      limit = nf - count;
      for (w = 32'(hint_frame) / WORD_BITS; w < NUM_WORDS && w * WORD_BITS <= limit; w++) begin
         if (shadow_used[w] != WORD_FULL) begin
            found = 1'b1;
            break;
         end
      end
      if (!found) return grant;
      run_start = w * WORD_BITS;
      run = 0;
      f = run_start;
      while (run_start <= limit && f < nf) begin
         if (frame_is_used(f)) begin
            run_start = f + 1;
            run = 0;
         end else begin
            run++;
            if (run == count) begin
               for (k = 0; k < count; k++) mark_frame(run_start + k, 1'b1);
               grant.frame_index = run_start[IDX_W-1:0];
               grant.ok = 1'b1;
               return grant;
            end
         end
         f++;
      end
      return grant;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) shadow_used[w] = WORD_FULL;
         frames_present = fbra_pkg::NUM_FRAMES_RST;
         hint_frame = fbra_pkg::SEARCH_START_RST;
         pending_grants.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               fbra_pkg::CSR_NUM_FRAMES:   frames_present = csr_wdata;
               fbra_pkg::CSR_SEARCH_START: hint_frame = csr_wdata[START_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_grants.size() == 0) begin
               report_failure($sformatf("response with no request pending (frame_index %0d ok %0b)",
                                        rsp_frame_index, rsp_ok));
            end else begin
               want = pending_grants.pop_front();
               if (rsp_frame_index !== want.frame_index)
                  report_failure($sformatf("frame_index: got %0d, expected %0d",
                                           rsp_frame_index, want.frame_index));
               if (rsp_ok !== want.ok)
                  report_failure($sformatf("ok: got %0b, expected %0b", rsp_ok, want.ok));
            end
         end
         if (req_valid && !req_stall)
            pending_grants.push_back(predict_grant(req_type, req_start_frame, req_run_length));
      end
      outstanding = pending_grants.size();
   end

endmodule

// File: sim/frame_bitmap_run_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_bitmap_run_allocator_core_tb
// Drives allocate and free requests into the frame allocator: a directed
// opening over the corner cases, then random phases under a range of frame
// counts and search hints, with bursty requests and a stalling receiver.
// A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module frame_bitmap_run_allocator_core_tb;

   localparam int START_W       = fbra_pkg::START_W;
   localparam int LEN_W         = fbra_pkg::LEN_W;
   localparam int IDX_W         = fbra_pkg::IDX_W;
   localparam int NF_W          = fbra_pkg::NF_W;
   localparam int CSR_W         = fbra_pkg::CSR_W;
   localparam int MAX_RUN       = fbra_pkg::DEF_MAX_RUN;
   localparam int CLOCK_PERIOD  = 20;
   localparam int CYCLE_LIMIT   = 20_000_000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int SETTLE_CYCLES = 64;

   typedef enum {STALL_NEVER, STALL_SCATTER, STALL_BURST} stall_mode_type;
   typedef enum {PHASE_SMALL, PHASE_FULL, PHASE_TOP_HINT, PHASE_EMPTY} phase_kind_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_type        = fbra_pkg::REQ_ALLOC;
   logic [START_W-1:0] req_start_frame = '0;
   logic [LEN_W-1:0]   req_run_length  = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [IDX_W-1:0]   rsp_frame_index;
   logic               rsp_ok;
   logic               csr_wr_en       = 1'b0;
   logic [CSR_W-1:0]   csr_index       = fbra_pkg::CSR_NUM_FRAMES;
   logic [NF_W-1:0]    csr_wdata       = '0;

   int          outstanding;
   int          fail_count;
   int unsigned cycle_count = 0;

   // sender pacing: requests go out in bursts, with gaps between bursts unless no_gaps is set
   int burst_left = 0;
   bit no_gaps    = 1'b0;

   // receiver pacing
   stall_mode_type stall_mode = STALL_NEVER;
   int             mode_left  = 0;
   int             stall_run  = 0;

   frame_bitmap_run_allocator_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_start_frame (req_start_frame),
      .req_run_length  (req_run_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_index (rsp_frame_index),
      .rsp_ok          (rsp_ok),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   fbra_grant_checker u_grant_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_start_frame (req_start_frame),
      .req_run_length  (req_run_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_index (rsp_frame_index),
      .rsp_ok          (rsp_ok),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .outstanding     (outstanding),
      .fail_count      (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Guard against a hung block: a failed allocate over the full map scans
   // every frame, so the limit is sized for many of those plus the sweep.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: switch at random between no stalls, scattered stalls and stall
   // bursts, so stalls land on every phase of the work.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
         STALL_NEVER: rsp_stall <= 1'b0;
         STALL_SCATTER: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               rsp_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_run = $urandom_range(0, 7);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      endcase
   end

   // Present one request and hold it until the transfer happens. Valid is
   // only dropped when a gap opens, so a burst keeps valid high throughout.
   task automatic send_request(input logic kind, input logic [START_W-1:0] start,
                               input logic [LEN_W-1:0] len);
      int gap_cycles;
      gap_cycles = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!no_gaps) gap_cycles = $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      if (gap_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (gap_cycles) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_start_frame <= start;
      req_run_length  <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold off until every expected response has been taken.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // Registers change only with the block idle.
   task automatic write_register(input logic [CSR_W-1:0] index, input logic [NF_W-1:0] value);
      drain_responses();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [LEN_W-1:0] pick_length(input int typical_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return LEN_W'($urandom_range(1, typical_max));
      if (r < 92) return LEN_W'($urandom_range(1, MAX_RUN));
      if (r < 96) return '0;
      return LEN_W'($urandom_range(MAX_RUN + 1, 511));
   endfunction

   task automatic run_directed();
      // every frame starts used, so the first allocate finds nothing
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd1);
      send_request(fbra_pkg::REQ_FREE, 16'd0, 9'd256);
      // zero length and lengths past the largest run both fail
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd0);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd257);
      send_request(fbra_pkg::REQ_ALLOC, 16'hFFFF, 9'd511);
      // a run at frame 0 is a real success
      send_request(fbra_pkg::REQ_ALLOC, 16'hFFFF, 9'd1);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd255);
      // an oversized free clears only the largest run
      send_request(fbra_pkg::REQ_FREE, 16'd0, 9'd511);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd256);
      // free running off the top of the map, and a zero-length free
      send_request(fbra_pkg::REQ_FREE, 16'hFFC0, 9'd256);
      send_request(fbra_pkg::REQ_FREE, 16'd100, 9'd0);
      // hint in the last word: the last possible start fits, then nothing
      write_register(fbra_pkg::CSR_SEARCH_START, 17'd65535);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd64);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd1);
      // no frames present
      write_register(fbra_pkg::CSR_NUM_FRAMES, 17'd0);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd1);
      // small system: runs longer than the system, exact fit at the limit,
      // frames cleared above num_frames that must never be handed out
      write_register(fbra_pkg::CSR_NUM_FRAMES, 17'd100);
      write_register(fbra_pkg::CSR_SEARCH_START, 17'd0);
      send_request(fbra_pkg::REQ_FREE, 16'd0, 9'd100);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd101);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd100);
      send_request(fbra_pkg::REQ_FREE, 16'd90, 9'd20);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd11);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd10);
      // hint beyond the frames present
      write_register(fbra_pkg::CSR_SEARCH_START, 17'd200);
      send_request(fbra_pkg::REQ_FREE, 16'd0, 9'd50);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd1);
      // frame count above the map size acts as the full map
      write_register(fbra_pkg::CSR_NUM_FRAMES, 17'd131071);
      write_register(fbra_pkg::CSR_SEARCH_START, 17'd64);
      send_request(fbra_pkg::REQ_ALLOC, 16'd0, 9'd5);
      send_request(fbra_pkg::REQ_FREE, 16'd0, 9'd256);
   endtask

   task automatic run_random_phase(input phase_kind_type kind, input int item_count,
                                   input int frames_now);
      logic               op;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      int                 hi;
      hi = frames_now + 63;
      if (hi > 65535) hi = 65535;
      for (int n = 0; n < item_count; n++) begin
         // now and then let everything drain before carrying on
         if ($urandom_range(0, 49) == 0) drain_responses();
         start = START_W'($urandom());
         if ($urandom_range(0, 1) == 0) begin
            op  = fbra_pkg::REQ_ALLOC;
            len = pick_length(kind == PHASE_FULL ? 32 : 48);
         end else begin
            op = fbra_pkg::REQ_FREE;
            case (kind)
               PHASE_FULL: len = LEN_W'($urandom_range(64, MAX_RUN));
               PHASE_TOP_HINT: begin
                  start = START_W'($urandom_range(65280, 65535));
                  len   = pick_length(64);
               end
               PHASE_SMALL: begin
                  if ($urandom_range(0, 99) < 85) start = START_W'($urandom_range(0, hi));
                  len = pick_length(48);
               end
               default: len = pick_length(48);
            endcase
         end
         send_request(op, start, len);
      end
   endtask

   initial begin
      int             items_sent;
      int             phase;
      int             frames_now;
      int             hint_now;
      int             item_count;
      int             r;
      phase_kind_type kind;

      items_sent = 0;
      phase      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      while (items_sent < RANDOM_ITEMS) begin
         // most phases use a small system so failed searches stay short;
         // a few cover the full map, the top hint and an empty system
         case (phase)
            2: begin
               kind       = PHASE_FULL;
               frames_now = 131071;
               hint_now   = $urandom_range(0, 65535);
               item_count = 30;
            end
            5: begin
               kind       = PHASE_TOP_HINT;
               frames_now = 65536;
               hint_now   = 65535;
               item_count = 20;
            end
            8: begin
               kind       = PHASE_EMPTY;
               frames_now = 0;
               hint_now   = $urandom_range(0, 65535);
               item_count = 10;
            end
            default: begin
               kind       = PHASE_SMALL;
               frames_now = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 63)
                                                         : $urandom_range(64, 1024);
               r = $urandom_range(0, 99);
               if (r < 20) hint_now = 0;
               else if (r < 90) hint_now = $urandom_range(0, frames_now / 2);
               else hint_now = $urandom_range(frames_now, 65535);
               item_count = $urandom_range(40, 120);
            end
         endcase
         write_register(fbra_pkg::CSR_NUM_FRAMES, NF_W'(frames_now));
         write_register(fbra_pkg::CSR_SEARCH_START, NF_W'(hint_now));
         no_gaps = ($urandom_range(0, 3) == 0);
         run_random_phase(kind, item_count, frames_now);
         items_sent += item_count;
         phase++;
      end

      // let the last responses arrive, then watch for stray ones
      drain_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
